### hw/rtl/lfuc_pkg.sv
// ----------------------------------------------------------------------------
// LFU cache package
// Shared widths, reset values and command codes for the LFU cache with
// LRU tie-break.
// ----------------------------------------------------------------------------
package lfuc_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int COUNT_BITS_DEF = 16;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Update applied by the whole row of cells in the same cycle.
  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_TOUCH   = 2'd1,
    CMD_INSERT  = 2'd2,
    CMD_REPLACE = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic                      wr_data;
    logic signed [KEY_W-1:0]   key;
    logic signed [DATA_W-1:0]  data;
  } cell_cmd_t;

endpackage

### hw/rtl/lfuc_if.sv
// ----------------------------------------------------------------------------
// LFU cache channel interfaces
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface lfuc_req_if import lfuc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic signed [KEY_W-1:0]  lookup_key;
  logic signed [DATA_W-1:0] write_value;

  modport source (output valid, operation, lookup_key, write_value, input ready);
  modport sink   (input valid, operation, lookup_key, write_value, output ready);
endinterface

interface lfuc_rsp_if import lfuc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic signed [DATA_W-1:0] read_value;

  modport source (output valid, hit, read_value, input ready);
  modport sink   (input valid, hit, read_value, output ready);
endinterface

interface lfuc_cfg_if import lfuc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

### hw/rtl/lfuc_cell.sv
// ----------------------------------------------------------------------------
// LFU cache cell
// Holds one cache entry, compares it against the lookup key, applies the
// row-wide update command and forms one stage of the victim search chain.
// ----------------------------------------------------------------------------
module lfuc_cell import lfuc_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int RANK_W     = 4,
  parameter int IDX_W      = 4,
  parameter int IDX        = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [KEY_W-1:0]  lookup_key,
  input  cell_cmd_t                cmd,
  input  logic                     sel,
  input  logic [RANK_W-1:0]        ref_rank,
  input  logic                     cand_in_found,
  input  logic [COUNT_BITS-1:0]    cand_in_count,
  input  logic [RANK_W-1:0]        cand_in_rank,
  input  logic [IDX_W-1:0]         cand_in_idx,
  output logic                     cand_out_found,
  output logic [COUNT_BITS-1:0]    cand_out_count,
  output logic [RANK_W-1:0]        cand_out_rank,
  output logic [IDX_W-1:0]         cand_out_idx,
  output logic                     entry_valid,
  output logic                     key_match,
  output logic signed [DATA_W-1:0] entry_data,
  output logic [RANK_W-1:0]        entry_rank
);

  logic                    valid;
  logic signed [KEY_W-1:0] key;
  logic signed [DATA_W-1:0] data;
  logic [COUNT_BITS-1:0]   count;
  logic [RANK_W-1:0]       rank;
  logic                    take;
  logic                    new_entry;

  assign entry_valid = valid;
  assign entry_data  = data;
  assign entry_rank  = rank;
  assign key_match   = valid && (key == lookup_key);

  // This entry beats the incoming candidate when it is used less often, or
  // equally often but less recently.
  assign take = valid && (!cand_in_found || (count < cand_in_count) ||
                ((count == cand_in_count) && (rank > cand_in_rank)));

  always_ff @(posedge clk) begin
    if (take) begin
      cand_out_found <= 1'b1;
      cand_out_count <= count;
      cand_out_rank  <= rank;
      cand_out_idx   <= IDX_W'(IDX);
    end else begin
      cand_out_found <= cand_in_found;
      cand_out_count <= cand_in_count;
      cand_out_rank  <= cand_in_rank;
      cand_out_idx   <= cand_in_idx;
    end
  end

  assign new_entry = sel && ((cmd.kind == CMD_INSERT) || (cmd.kind == CMD_REPLACE));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (new_entry) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.kind)
      CMD_TOUCH: begin
        if (sel) begin
          rank <= '0;
          if (count != {COUNT_BITS{1'b1}}) begin
            count <= count + COUNT_BITS'(1);
          end
          if (cmd.wr_data) begin
            data <= cmd.data;
          end
        end else if (valid && (rank < ref_rank)) begin
          rank <= rank + RANK_W'(1);
        end
      end
      CMD_INSERT: begin
        if (sel) begin
          key   <= cmd.key;
          data  <= cmd.data;
          count <= COUNT_BITS'(1);
          rank  <= '0;
        end else if (valid) begin
          rank <= rank + RANK_W'(1);
        end
      end
      CMD_REPLACE: begin
        // Removing the victim and inserting in front nets out to a step down
        // only for entries more recent than the victim.
        if (sel) begin
          key   <= cmd.key;
          data  <= cmd.data;
          count <= COUNT_BITS'(1);
          rank  <= '0;
        end else if (valid && (rank < ref_rank)) begin
          rank <= rank + RANK_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### hw/rtl/lfu_cache_lru_tiebreak_top.sv
// A get result is loaded into the output register from S_ACT; the load waits only while an
// earlier reply is still held in that register.
// Gets, put hits and non-evicting puts pass through S_ACT, one request at a time.
// An evicting put also passes S_SCAN and S_REPL; the victim search walks the row one cell per cycle.
// Reset (synchronous, active high) clears all entry valid bits and the occupancy
// at once and sets capacity to 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
// LFU cache with LRU tie-break
// Fully associative key-value cache built from a row of entry cells with a
// small sequencer for lookup, update, insert and eviction.
// ----------------------------------------------------------------------------
module lfu_cache_lru_tiebreak_top import lfuc_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lfuc_cfg_if.sink   cfg,
  lfuc_req_if.sink   req,
  lfuc_rsp_if.source rsp
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = ((OCC_W > CAP_W) ? OCC_W : CAP_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ACT  = 4'b0010,
    S_SCAN = 4'b0100,
    S_REPL = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [CAP_W-1:0]         capacity;
  logic [OCC_W-1:0]         occ, occ_next;
  logic [IDX_W-1:0]         scan_cnt, scan_cnt_next;
  logic                     op_q;
  logic signed [KEY_W-1:0]  key_q;
  logic signed [DATA_W-1:0] value_q;
  logic [ENTRIES-1:0]       match_q;

  logic                     out_valid, out_valid_next;
  logic                     out_hit;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_load;

  // Cell row signals.
  logic [ENTRIES-1:0]       valid_vec;
  logic [ENTRIES-1:0]       match_vec;
  logic signed [DATA_W-1:0] cell_data [ENTRIES];
  logic [RANK_W-1:0]        cell_rank [ENTRIES];
  logic [ENTRIES:0]         c_found;
  logic [COUNT_BITS-1:0]    c_count [ENTRIES+1];
  logic [RANK_W-1:0]        c_rank  [ENTRIES+1];
  logic [IDX_W-1:0]         c_idx   [ENTRIES+1];

  cell_cmd_t                cmd;
  logic [ENTRIES-1:0]       sel;
  logic [RANK_W-1:0]        ref_rank;

  logic                     hit_q;
  logic signed [DATA_W-1:0] hit_data;
  logic [RANK_W-1:0]        hit_rank;
  logic [ENTRIES-1:0]       free_oh;
  logic [ENTRIES-1:0]       vic_oh;
  logic [CMP_W-1:0]         cap_eff;
  logic                     full;
  logic                     accept;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      capacity <= cfg.capacity;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= req.operation;
      key_q   <= req.lookup_key;
      value_q <= req.write_value;
      match_q <= match_vec;
    end
  end

  // Row of entry cells; the candidate chain runs from cell 0 upward.
  assign c_found[0] = 1'b0;
  assign c_count[0] = '0;
  assign c_rank[0]  = '0;
  assign c_idx[0]   = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lfuc_cell #(
      .COUNT_BITS (COUNT_BITS),
      .RANK_W     (RANK_W),
      .IDX_W      (IDX_W),
      .IDX        (i)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .lookup_key     (req.lookup_key),
      .cmd            (cmd),
      .sel            (sel[i]),
      .ref_rank       (ref_rank),
      .cand_in_found  (c_found[i]),
      .cand_in_count  (c_count[i]),
      .cand_in_rank   (c_rank[i]),
      .cand_in_idx    (c_idx[i]),
      .cand_out_found (c_found[i+1]),
      .cand_out_count (c_count[i+1]),
      .cand_out_rank  (c_rank[i+1]),
      .cand_out_idx   (c_idx[i+1]),
      .entry_valid    (valid_vec[i]),
      .key_match      (match_vec[i]),
      .entry_data     (cell_data[i]),
      .entry_rank     (cell_rank[i])
    );
  end

  always_comb begin
    hit_data = '0;
    hit_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_q[i]) begin
        hit_data = hit_data | cell_data[i];
        hit_rank = hit_rank | cell_rank[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      vic_oh[i] = (c_idx[ENTRIES] == IDX_W'(i));
    end
  end

  assign hit_q   = |match_q;
  // Lowest free slot.
  assign free_oh = ~valid_vec & (valid_vec + ENTRIES'(1));
  assign cap_eff = (CMP_W'(capacity) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(capacity);
  assign full    = (CMP_W'(occ) >= cap_eff);
  assign out_load = (state == S_ACT) && (op_q == OP_GET) && (!out_valid || rsp.ready);

  always_comb begin
    state_next     = state;
    occ_next       = occ;
    scan_cnt_next  = scan_cnt;
    out_valid_next = out_valid;
    cmd.kind       = CMD_NONE;
    cmd.wr_data    = 1'b0;
    cmd.key        = key_q;
    cmd.data       = value_q;
    sel            = '0;
    ref_rank       = hit_rank;

    if (out_valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_ACT;
        end
      end
      S_ACT: begin
        if (op_q == OP_GET) begin
          if (out_load) begin
            out_valid_next = 1'b1;
            state_next     = S_IDLE;
            if (hit_q) begin
              cmd.kind = CMD_TOUCH;
              sel      = match_q;
            end
          end
        end else if (capacity == '0) begin
          state_next = S_IDLE;
        end else if (hit_q) begin
          cmd.kind    = CMD_TOUCH;
          cmd.wr_data = 1'b1;
          sel         = match_q;
          state_next  = S_IDLE;
        end else if (full) begin
          scan_cnt_next = '0;
          state_next    = S_SCAN;
        end else begin
          cmd.kind   = CMD_INSERT;
          sel        = free_oh;
          occ_next   = occ + OCC_W'(1);
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        // The candidate passes through the registered cell stages to reach the end of the row.
        scan_cnt_next = scan_cnt + IDX_W'(1);
        if (scan_cnt == IDX_W'(ENTRIES - 1)) begin
          state_next = S_REPL;
        end
      end
      S_REPL: begin
        cmd.kind   = CMD_REPLACE;
        sel        = vic_oh;
        ref_rank   = c_rank[ENTRIES];
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      scan_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      occ       <= occ_next;
      scan_cnt  <= scan_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit   <= hit_q;
      out_value <= hit_q ? hit_data : MISS_VALUE;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.hit        = out_hit;
  assign rsp.read_value = out_value;

`ifndef SYNTHESIS
  a_match_onehot: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACT) |-> $onehot0(match_q))
    else $error("more than one entry matched the lookup key");

  a_occ_tracks_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(occ))
    else $error("occupancy differs from the number of valid entries");

  a_victim_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_REPL) |-> c_found[ENTRIES])
    else $error("victim search ended without a candidate");

  a_evict_keeps_occ: assert property (@(posedge clk) disable iff (rst)
    (state == S_REPL) |=> (occ == $past(occ)))
    else $error("replacement changed the occupancy");
`endif

endmodule

### sim/lfu_cache_lru_tiebreak_top_tb.sv
// ----------------------------------------------------------------------------
// LFU cache with LRU tie-break testbench
// Drives get and put transactions into the cache, predicts every get reply
// with a cycle-free model of the entry row kept in a small scoreboard, and
// compares the replies field by field. Covers the recency tie-break between
// equal counts, zero and oversized capacity, shrinking capacity below
// occupancy, and random traffic over a small key pool with idle gaps and a
// long reply backpressure stretch.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic        hit;
  logic [31:0] value;
} cache_reply_t;

class lfu_scoreboard #(int NUM = 16, int CNT_W = 16);
  localparam longint unsigned USE_MAX = (64'd1 << CNT_W) - 64'd1;

  bit              slot_used [NUM];
  logic [31:0]     slot_key  [NUM];
  logic [31:0]     slot_data [NUM];
  longint unsigned slot_uses [NUM];
  int unsigned     slot_age  [NUM];
  int unsigned     fill;
  logic [4:0]      capacity;
  cache_reply_t    replies[$];
  int              errors;

  function new();
    capacity = lfuc_pkg::CAP_RESET;
    fill     = 0;
    errors   = 0;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
  endfunction

  function void set_capacity(logic [4:0] c);
    capacity = c;
  endfunction

  function int pending();
    return replies.size();
  endfunction

  function int find_key(logic [31:0] k);
    for (int i = 0; i < NUM; i++)
      if (slot_used[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  // Age 0 is the most recent access; everything younger than the slot ages by one.
  function void promote(int s);
    int unsigned r;
    r = slot_age[s];
    for (int i = 0; i < NUM; i++)
      if (slot_used[i] && slot_age[i] < r) slot_age[i]++;
    slot_age[s] = 0;
    if (slot_uses[s] < USE_MAX) slot_uses[s]++;
  endfunction

  function int pick_eviction();
    int v;
    v = -1;
    for (int i = 0; i < NUM; i++) begin
      if (!slot_used[i]) continue;
      if (v < 0 || slot_uses[i] < slot_uses[v] ||
          (slot_uses[i] == slot_uses[v] && slot_age[i] > slot_age[v]))
        v = i;
    end
    return v;
  endfunction

  function void drop_slot(int s);
    int unsigned r;
    r = slot_age[s];
    slot_used[s] = 1'b0;
    for (int i = 0; i < NUM; i++)
      if (slot_used[i] && slot_age[i] > r) slot_age[i]--;
    if (fill > 0) fill--;
  endfunction

  function void place(logic [31:0] k, logic [31:0] d);
    int          s;
    int unsigned lim;
    s   = -1;
    lim = (capacity > NUM) ? NUM : capacity;
    if (fill >= lim) begin
      s = pick_eviction();
      if (s >= 0) drop_slot(s);
    end
    if (s < 0) begin
      for (int i = 0; i < NUM; i++)
        if (!slot_used[i]) begin
          s = i;
          break;
        end
    end
    if (s < 0) return;
    for (int i = 0; i < NUM; i++)
      if (slot_used[i]) slot_age[i]++;
    slot_used[s] = 1'b1;
    slot_key[s]  = k;
    slot_data[s] = d;
    slot_uses[s] = 1;
    slot_age[s]  = 0;
    fill++;
  endfunction

  function void note_request(logic op, logic [31:0] k, logic [31:0] d);
    int           s;
    cache_reply_t r;
    s = find_key(k);
    if (op == lfuc_pkg::OP_GET) begin
      if (s >= 0) begin
        r.hit   = 1'b1;
        r.value = slot_data[s];
        promote(s);
      end else begin
        r.hit   = 1'b0;
        r.value = lfuc_pkg::MISS_VALUE;
      end
      replies.push_back(r);
      return;
    end
    if (capacity == 0) return;
    if (s >= 0) begin
      slot_data[s] = d;
      promote(s);
    end else begin
      place(k, d);
    end
  endfunction

  task report_mismatch(string msg);
    if (errors < 40) $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  task check_reply(logic hit, logic [31:0] value);
    cache_reply_t want;
    if (replies.size() == 0) begin
      report_mismatch($sformatf("reply with no get pending: hit=%0b value=%h", hit, value));
      return;
    end
    want = replies.pop_front();
    if (hit !== want.hit)
      report_mismatch($sformatf("hit is %0b, predicted %0b", hit, want.hit));
    if (value !== want.value)
      report_mismatch($sformatf("read_value is %h, predicted %h", value, want.value));
  endtask
endclass

module lfu_cache_lru_tiebreak_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lfuc_pkg::*;

  localparam int ENTRIES     = ENTRIES_DEF;
  localparam int COUNT_BITS  = COUNT_BITS_DEF;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int TIE_HITS    = 4;
  localparam int SEG_ITEMS   = 110;
  localparam int HOLD_CYCLES = 400;

  localparam logic [31:0] KEY_A = 32'h0000_A5A5;
  localparam logic [31:0] KEY_B = 32'h0000_5A5A;
  localparam logic [31:0] KEY_C = 32'h0000_C3C3;

  logic clk;
  logic rst;

  lfuc_cfg_if cfg_ch ();
  lfuc_req_if req_ch ();
  lfuc_rsp_if rsp_ch ();

  lfu_cache_lru_tiebreak_top #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  lfu_scoreboard #(ENTRIES, COUNT_BITS) sb;

  int          send_idle;
  int          recv_idle;
  bit          pressure_go;
  logic        rsp_hold;
  int          cycles;
  logic [31:0] key_pool [24];
  logic [CAP_W-1:0] seg_caps [5];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Reply side: check each accepted transaction, then pick the next ready.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_reply(rsp_ch.hit, rsp_ch.read_value);
    rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle);
  end

  // One long backpressure stretch so a held reply stalls further requests.
  initial begin
    rsp_hold = 1'b0;
    wait (pressure_go);
    @(posedge clk);
    rsp_hold <= 1'b1;
    for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
    rsp_hold <= 1'b0;
  end

  task automatic send_req(input logic op, input logic [31:0] key, input logic [31:0] wv);
    while ($urandom_range(99) < send_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.operation   <= op;
    req_ch.lookup_key  <= key;
    req_ch.write_value <= wv;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(op, key, wv);
  endtask

  // Wait until every reply is back and a possible eviction walk has finished.
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (ENTRIES + 6) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    settle();
    cfg_ch.valid    <= 1'b1;
    cfg_ch.capacity <= c;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    sb.set_capacity(c);
  endtask

  // Mostly keys from a small pool so gets hit and puts evict.
  function automatic logic [31:0] pick_key();
    if ($urandom_range(9) == 0) return $urandom;
    return key_pool[$urandom_range(23)];
  endfunction

  initial begin
    sb          = new();
    send_idle   = 11;
    recv_idle   = 45;
    pressure_go = 1'b0;
    rst         = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.operation   = OP_GET;
    req_ch.lookup_key  = '0;
    req_ch.write_value = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.capacity = CAP_RESET;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 24; i++) key_pool[i] = $urandom;
    seg_caps[0] = 5'd16;
    seg_caps[1] = 5'd5;
    seg_caps[2] = 5'd31;
    seg_caps[3] = 5'd0;
    seg_caps[4] = 5'd2;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Equal use counts on a two-entry cache: B was touched last, so the put
    // of C evicts A as the less recently used of the two.
    write_capacity(5'd2);
    send_req(OP_PUT, KEY_A, 32'hA0A0_0001);
    send_req(OP_PUT, KEY_B, 32'hB0B0_0002);
    for (int i = 0; i < TIE_HITS; i++) send_req(OP_GET, KEY_A, $urandom);
    for (int i = 0; i < TIE_HITS; i++) send_req(OP_GET, KEY_B, $urandom);
    send_req(OP_PUT, KEY_C, 32'hC0C0_0003);
    send_req(OP_GET, KEY_B, '0);
    send_req(OP_GET, KEY_A, '0);
    send_req(OP_GET, KEY_C, '0);

    // Field extremes, put hit overwrite, and a stored value equal to the miss value.
    write_capacity(5'd16);
    send_req(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_req(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_req(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_req(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send_req(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(OP_GET, 32'h8000_0000, '0);
    send_req(OP_GET, 32'h7FFF_FFFF, '0);
    send_req(OP_GET, 32'h0000_0000, '0);
    send_req(OP_GET, 32'hFFFF_FFFF, '0);
    send_req(OP_PUT, 32'h0000_0000, 32'h1234_5678);
    send_req(OP_GET, 32'h0000_0000, '0);

    // Zero capacity ignores every put, but stored entries still hit.
    write_capacity(5'd0);
    send_req(OP_PUT, 32'h0000_0099, 32'h0000_0001);
    send_req(OP_GET, 32'h0000_0099, '0);
    send_req(OP_GET, 32'h8000_0000, '0);
    send_req(OP_PUT, 32'h0000_0000, 32'h0000_0005);
    send_req(OP_GET, 32'h0000_0000, '0);

    // Capacity above the number of entries behaves as a full row.
    write_capacity(5'd31);
    send_req(OP_PUT, 32'h0000_0011, 32'h5555_AAAA);
    send_req(OP_GET, 32'h0000_0011, '0);

    // Capacity below occupancy: each put miss swaps one entry out.
    write_capacity(5'd3);
    send_req(OP_PUT, 32'h0000_0022, 32'hAAAA_5555);
    send_req(OP_PUT, 32'h0000_0033, 32'h0F0F_F0F0);
    send_req(OP_GET, 32'h0000_0022, '0);
    send_req(OP_GET, 32'h0000_0033, '0);
    send_req(OP_GET, 32'h7FFF_FFFF, '0);

    for (int seg = 0; seg < 5; seg++) begin
      write_capacity(seg_caps[seg]);
      if (seg == 2) begin
        send_idle = 45;
        recv_idle = 11;
      end else if (seg == 4) begin
        send_idle   = 0;
        recv_idle   = 0;
        pressure_go = 1'b1;
      end
      for (int i = 0; i < SEG_ITEMS; i++)
        send_req(logic'($urandom_range(1)), pick_key(), $urandom);
    end

    settle();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
